>>> rtl/core/circular_fifo_queue_top_defines.svh
// Assertion macros for the checker of the queue.
`ifndef CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFQ_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFQ_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

>>> rtl/core/cfq_pkg.sv
package cfq_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes.
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

>>> rtl/core/circular_fifo_queue_top.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------
// request   | start, accepted when !busy| cmd, push_value
// result    | result_strobe, one cycle  | item_value, status, last
// config    | cfg_wr_en, no wait        | cfg_wr_data (capacity)
//
// Enqueue, and any request on an empty queue, answers the cycle after it with
// busy low. Any other dequeue passes through S_DEQ, where the registered read of
// the slot memory is taken, with busy high in that state. Display streams the n
// stored words from S_DISP, one word per cycle from the single memory read port.
// Synchronous reset clears the pointers and sets the empty flag; the slot memory
// itself is not cleared. The receiver cannot stall results.
module circular_fifo_queue_top
  import cfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     result_strobe,
  output logic signed [WORD_W-1:0] item_value,
  output logic [1:0]               status,
  output logic                     last,
  input  logic                     cfg_wr_en,
  input  logic [CAP_W-1:0]         cfg_wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DEQ, S_DISP} state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [IW-1:0]     head_index;
  logic [IW-1:0]     tail_index;
  logic              is_empty;
  logic [IW-1:0]     disp_idx;
  logic [CW-1:0]     disp_n;
  logic              disp_fin;

  logic [WORD_W-1:0] slot_store [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [IW-1:0]     mem_raddr;
  logic [IW-1:0]     mem_waddr;
  logic              mem_we;

  logic [CW-1:0]     cap_eff;
  logic [IW-1:0]     head_inc;
  logic [IW-1:0]     tail_inc;
  logic [IW-1:0]     disp_inc;
  logic [CW-1:0]     disp_n_next;
  logic              disp_fin_next;
  logic              accept;
  logic              q_full;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] wide;
    wide = CW'(idx) + CW'(1);
    return (wide == cap) ? '0 : IW'(wide);
  endfunction

  // Zero capacity acts as one, anything above the built depth as the depth.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  assign head_inc      = ring_inc(head_index, cap_eff);
  assign tail_inc      = ring_inc(tail_index, cap_eff);
  assign disp_inc      = ring_inc(disp_idx, cap_eff);
  assign disp_n_next   = disp_n + CW'(1);
  assign disp_fin_next = (disp_inc == tail_index) || (disp_n_next + CW'(1) == cap_eff);
  assign q_full        = (tail_inc == head_index);

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  assign mem_we    = accept && (cmd == CMD_ENQ) && (is_empty || !q_full);
  assign mem_waddr = is_empty ? '0 : tail_inc;
  // While idle the head is read for a dequeue or the first displayed word.
  assign mem_raddr = (state == S_DISP) ? disp_inc : head_index;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_store[mem_waddr] <= push_value;
    end
    rd_data <= slot_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= CAP_RESET;
      head_index    <= '0;
      tail_index    <= '0;
      is_empty      <= 1'b1;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_wr_en) begin
        capacity   <= cfg_wr_data;
        head_index <= '0;
        tail_index <= '0;
        is_empty   <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_ENQ: begin
                result_strobe <= 1'b1;
                item_value    <= '0;
                last          <= 1'b1;
                if (is_empty) begin
                  head_index <= '0;
                  tail_index <= '0;
                  is_empty   <= 1'b0;
                  status     <= ST_OK;
                end else if (q_full) begin
                  status <= ST_FULL;
                end else begin
                  tail_index <= tail_inc;
                  status     <= ST_OK;
                end
              end
              CMD_DEQ: begin
                if (is_empty) begin
                  result_strobe <= 1'b1;
                  item_value    <= '0;
                  status        <= ST_EMPTY;
                  last          <= 1'b1;
                end else begin
                  // Removing the only word returns the queue to empty.
                  if (head_index == tail_index) begin
                    head_index <= '0;
                    tail_index <= '0;
                    is_empty   <= 1'b1;
                  end else begin
                    head_index <= head_inc;
                  end
                  state <= S_DEQ;
                end
              end
              CMD_DISP: begin
                if (is_empty) begin
                  result_strobe <= 1'b1;
                  item_value    <= '0;
                  status        <= ST_EMPTY;
                  last          <= 1'b1;
                end else begin
                  disp_idx <= head_index;
                  disp_n   <= '0;
                  disp_fin <= (head_index == tail_index) || (cap_eff == CW'(1));
                  state    <= S_DISP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DEQ: begin
          result_strobe <= 1'b1;
          item_value    <= rd_data;
          status        <= ST_OK;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        S_DISP: begin
          result_strobe <= 1'b1;
          item_value    <= rd_data;
          status        <= ST_OK;
          last          <= disp_fin;
          if (disp_fin) begin
            state <= S_IDLE;
          end else begin
            disp_idx <= disp_inc;
            disp_n   <= disp_n_next;
            disp_fin <= disp_fin_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cfq_checker.sv
`include "circular_fifo_queue_top_defines.svh"

module cfq_checker
  import cfq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               cmd,
  input logic                     result_strobe,
  input logic signed [WORD_W-1:0] item_value,
  input logic [1:0]               status,
  input logic                     last
);

  logic res_failed;
  logic enq_taken;
  logic deq_taken;

  assign res_failed = result_strobe && status != ST_OK;
  assign enq_taken  = start && !busy && cmd == CMD_ENQ;
  assign deq_taken  = start && !busy && cmd == CMD_DEQ;

  // A failed request carries no word and always ends its request.
  `CFQ_ASSERT_IMP(a_nok_zero, clk, rst, res_failed, item_value == '0 && last)

  // An enqueue answers in the very next cycle with a single result.
  `CFQ_ASSERT_NEXT(a_enq_next, clk, rst, enq_taken, result_strobe && last && status != ST_EMPTY)

  // A dequeue either answers empty at once or waits in the busy state on the memory read.
  `CFQ_ASSERT_NEXT(a_deq_wait, clk, rst, deq_taken, busy != result_strobe)

  // A display stream has no gaps between its words.
  `CFQ_ASSERT_NEXT(a_disp_run, clk, rst, result_strobe && !last, result_strobe && status == ST_OK)

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (.*);
